FILE: hw/rtl/msgp_pkg.sv
// Shared types and constants for the task mailbox message pool.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package msgp_pkg;

  localparam int POOL_SIZE    = 32;
  localparam int TASK_ID_BITS = 6;
  localparam int VALUE_BITS   = 32;

  typedef logic [TASK_ID_BITS-1:0] task_id_t;
  typedef logic [VALUE_BITS-1:0]   value_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_GET = 1'b1
  } opcode_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam task_id_t NULL_ID = '0;

  // Contents of one message slot.
  typedef struct packed {
    logic     valid;
    task_id_t sender;
    task_id_t destination;
    value_t   payload;
  } slot_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic     load_match;
    logic     is_get;
    logic     shift;
    logic     append;
    task_id_t sender;
    task_id_t destination;
    value_t   value;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msgp_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on msgp_pkg for field widths.
`default_nettype none

interface msgp_req_if;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  msgp_pkg::task_id_t    sender;
  msgp_pkg::task_id_t    destination;
  msgp_pkg::value_t      value;

  modport source (output valid, opcode, sender, destination, value, input ready);
  modport sink   (input valid, opcode, sender, destination, value, output ready);
endinterface

interface msgp_rsp_if;
  logic                  valid;
  logic                  ready;
  logic                  status;
  msgp_pkg::value_t      value_out;
  msgp_pkg::task_id_t    sender_out;

  modport source (output valid, status, value_out, sender_out, input ready);
  modport sink   (input valid, status, value_out, sender_out, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/task_mailbox_message_pool.sv
// Top level of the task mailbox message pool: request sequencer, row of
// slot cells and response register. Depends on msgp_pkg, msgp_if, msgp_cell.
//
//   Channel  Direction  Payload
//   req      in         opcode, sender, destination, value
//   rsp      out        status, value_out, sender_out
//
// Each request passes through S_MATCH, which compares all slots against it,
// and S_COMMIT, which resolves the oldest match along the cell row, shifts or
// appends, and loads the response register. A new request is taken in
// S_COMMIT as the last one commits. A response that waits on rsp holds the
// block in S_COMMIT. Reset empties the pool at once.
`default_nettype none

module task_mailbox_message_pool (
  input  wire logic   clk,
  input  wire logic   rst,
  msgp_req_if.sink    req,
  msgp_rsp_if.source  rsp
);
  import msgp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_COMMIT
  } state_t;

  state_t    state;
  opcode_t   req_op;
  task_id_t  req_sender;
  task_id_t  req_destination;
  value_t    req_value;

  logic      rsp_valid;
  logic      rsp_status;
  value_t    rsp_value;
  task_id_t  rsp_sender;

  cell_ctl_t ctl;
  slot_t     slots [POOL_SIZE];
  slot_t     next_slots [POOL_SIZE];
  logic      found [POOL_SIZE+1];
  logic      prev_valid [POOL_SIZE];
  logic      hits [POOL_SIZE];

  logic      out_free;
  logic      commit;
  logic      take;
  logic      ids_ok;
  logic      full;
  logic      any_hit;
  value_t    rd_value;
  task_id_t  rd_sender;
  logic      status_next;

  assign out_free = !rsp_valid || rsp.ready;
  assign commit   = (state == S_COMMIT) && out_free;
  assign take     = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) || commit;

  assign ids_ok  = (req_destination != NULL_ID) &&
                   ((req_op == OP_GET) || (req_sender != NULL_ID));
  assign full    = slots[POOL_SIZE-1].valid;
  assign any_hit = found[POOL_SIZE];

  always_comb begin
    ctl.load_match  = (state == S_MATCH);
    ctl.is_get      = (req_op == OP_GET);
    ctl.shift       = commit && (req_op == OP_GET);
    ctl.append      = commit && (req_op == OP_ADD) && ids_ok;
    ctl.sender      = req_sender;
    ctl.destination = req_destination;
    ctl.value       = req_value;
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    if (i == POOL_SIZE - 1) begin : g_last
      assign next_slots[i] = '0;
    end else begin : g_mid
      assign next_slots[i] = slots[i+1];
    end
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
    end else begin : g_body
      assign prev_valid[i] = slots[i-1].valid;
    end

    msgp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .next_slot  (next_slots[i]),
      .prev_valid (prev_valid[i]),
      .found_in   (found[i]),
      .slot       (slots[i]),
      .found_out  (found[i+1]),
      .hit        (hits[i])
    );
  end

  // At most one cell hits, so the read is an AND-OR across the row.
  always_comb begin
    rd_value  = '0;
    rd_sender = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      rd_value  = rd_value  | ({VALUE_BITS{hits[i]}} & slots[i].payload);
      rd_sender = rd_sender | ({TASK_ID_BITS{hits[i]}} & slots[i].sender);
    end
  end

  always_comb begin
    if (req_op == OP_ADD) begin
      status_next = (ids_ok && !full) ? STATUS_OK : STATUS_FAIL;
    end else begin
      status_next = (ids_ok && any_hit) ? STATUS_OK : STATUS_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= commit || (rsp_valid && !rsp.ready);
      if (commit) begin
        rsp_status <= status_next;
        rsp_value  <= rd_value;
        rsp_sender <= rd_sender;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (take) begin
            state <= S_MATCH;
          end else if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (take) begin
      req_op          <= opcode_t'(req.opcode);
      req_sender      <= req.sender;
      req_destination <= req.destination;
      req_value       <= req.value;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.value_out  = rsp_value;
  assign rsp.sender_out = rsp_sender;

endmodule

`default_nettype wire

FILE: hw/rtl/msgp_cell.sv
// One message slot of the compacted pool, with its match flag.
// Depends on msgp_pkg; instantiated in a row by task_mailbox_message_pool.
`default_nettype none

module msgp_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire msgp_pkg::cell_ctl_t ctl,
  input  wire msgp_pkg::slot_t    next_slot,
  input  wire logic               prev_valid,
  input  wire logic               found_in,
  output msgp_pkg::slot_t         slot,
  output logic                    found_out,
  output logic                    hit
);
  import msgp_pkg::*;

  logic match;
  logic cmp;

  // The oldest matching cell is the one with no match before it.
  assign found_out = found_in | match;
  assign hit       = match & ~found_in;

  assign cmp = slot.valid && (slot.destination == ctl.destination) &&
               ((ctl.sender == NULL_ID) || (slot.sender == ctl.sender));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
      match      <= 1'b0;
    end else begin
      if (ctl.load_match) begin
        match <= ctl.is_get & cmp;
      end
      // Removal pulls every later slot one place toward the head.
      if (ctl.shift && found_out) begin
        slot <= next_slot;
      end else if (ctl.append && !slot.valid && prev_valid) begin
        slot.valid       <= 1'b1;
        slot.sender      <= ctl.sender;
        slot.destination <= ctl.destination;
        slot.payload     <= ctl.value;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_task_mailbox_message_pool.sv
`timescale 1ns / 1ps
// Self-checking testbench for the task mailbox message pool: directed and random
// add/get transactions, checked against an in-bench mailbox predictor.
// Depends on msgp_pkg, msgp_if and the task_mailbox_message_pool RTL.

module tb_task_mailbox_message_pool;
  import msgp_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int SEGMENT_ITEMS = 40;

  typedef struct {
    task_id_t sender;
    task_id_t destination;
    value_t   payload;
  } pool_msg_t;

  typedef struct {
    logic     status;
    value_t   value_out;
    task_id_t sender_out;
  } mailbox_reply_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_t;

  class mailbox_pool_predictor;
    pool_msg_t      queued_msgs[$];
    mailbox_reply_t expected_replies[$];
    int             failures = 0;

    function int pending_count();
      return expected_replies.size();
    endfunction

    task report_mismatch(string what);
      if (failures < 100) begin
        $display("MISMATCH at %0t ns: %s", $time, what);
      end
      failures++;
    endtask

    // Messages are kept in arrival order, so the first match is the oldest one.
    function void take_request(opcode_t op, task_id_t snd, task_id_t dst, value_t val);
      mailbox_reply_t reply;
      pool_msg_t      msg;
      int             hit;
      reply = '{status: STATUS_FAIL, value_out: '0, sender_out: '0};
      if (op == OP_ADD) begin
        if (snd != NULL_ID && dst != NULL_ID && queued_msgs.size() < POOL_SIZE) begin
          msg.sender = snd;
          msg.destination = dst;
          msg.payload = val;
          queued_msgs.push_back(msg);
          reply.status = STATUS_OK;
        end
      end else if (dst != NULL_ID) begin
        hit = -1;
        for (int i = 0; i < queued_msgs.size() && hit < 0; i++) begin
          if (queued_msgs[i].destination == dst &&
              (snd == NULL_ID || queued_msgs[i].sender == snd)) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          reply.status = STATUS_OK;
          reply.value_out = queued_msgs[hit].payload;
          reply.sender_out = queued_msgs[hit].sender;
          queued_msgs.delete(hit);
        end
      end
      expected_replies.push_back(reply);
    endfunction

    task check_reply(logic status, value_t value_out, task_id_t sender_out);
      mailbox_reply_t exp;
      if (expected_replies.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
        return;
      end
      exp = expected_replies.pop_front();
      if (status !== exp.status) begin
        report_mismatch($sformatf("status %b, expected %b", status, exp.status));
      end
      if (value_out !== exp.value_out) begin
        report_mismatch($sformatf("value_out %h, expected %h", value_out, exp.value_out));
      end
      if (sender_out !== exp.sender_out) begin
        report_mismatch($sformatf("sender_out %0d, expected %0d", sender_out,
                                  exp.sender_out));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   replies_seen = 0;

  msgp_req_if req_bus ();
  msgp_rsp_if rsp_bus ();

  mailbox_pool_predictor mailbox_pred = new();

  task_mailbox_message_pool i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #6 clk = ~clk;

  function automatic int gap_length(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  function automatic task_id_t pick_task_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return NULL_ID;
    end else if (r < 85) begin
      return task_id_t'($urandom_range(1, 3));
    end else begin
      return task_id_t'($urandom_range(1, 63));
    end
  endfunction

  task automatic send_request(opcode_t op, task_id_t snd, task_id_t dst, value_t val);
    req_bus.valid <= 1'b1;
    req_bus.opcode <= op;
    req_bus.sender <= snd;
    req_bus.destination <= dst;
    req_bus.value <= val;
    do @(posedge clk); while (!req_bus.ready);
    mailbox_pred.take_request(op, snd, dst, val);
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      req_bus.valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      replies_seen++;
      mailbox_pred.check_reply(rsp_bus.status, rsp_bus.value_out, rsp_bus.sender_out);
    end
  end

  // Response side: random back-pressure, eager stretches, and one long hold-off.
  initial begin
    int stall_left;
    bit eager;
    bit long_hold_done;
    stall_left = 0;
    eager = 1'b0;
    long_hold_done = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && replies_seen >= 400) begin
        long_hold_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if ($urandom_range(0, 199) == 0) begin
        eager = !eager;
      end
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if (!eager && $urandom_range(0, 99) < 25) begin
        stall_left = gap_length(1'b0) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    traffic_mix_t mix;
    bit           no_gaps;
    int           add_pct;
    opcode_t      op;
    task_id_t     snd;
    task_id_t     dst;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.opcode = OP_ADD;
    req_bus.sender = NULL_ID;
    req_bus.destination = NULL_ID;
    req_bus.value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(OP_ADD, 6'd0, 6'd5, 32'h1234_5678);
    send_request(OP_ADD, 6'd5, 6'd0, 32'h8765_4321);
    send_request(OP_ADD, 6'd0, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_GET, 6'd0, 6'd0, 32'h0);
    send_request(OP_GET, 6'd0, 6'd7, 32'h0);
    send_request(OP_ADD, 6'd63, 6'd63, 32'hFFFF_FFFF);
    idle_for(gap_length(1'b1));
    send_request(OP_ADD, 6'd1, 6'd63, 32'h0);
    send_request(OP_ADD, 6'd2, 6'd1, 32'hA5A5_A5A5);
    send_request(OP_ADD, 6'd63, 6'd1, 32'h5A5A_5A5A);
    send_request(OP_ADD, 6'd42, 6'd21, 32'hDEAD_BEEF);
    send_request(OP_ADD, 6'd21, 6'd42, 32'h0F0F_F0F0);
    send_request(OP_GET, 6'd1, 6'd1, 32'h0);
    idle_for(gap_length(1'b1));
    send_request(OP_GET, 6'd63, 6'd1, 32'hFFFF_FFFF);
    send_request(OP_GET, 6'd0, 6'd63, 32'h0);
    send_request(OP_GET, 6'd0, 6'd63, 32'h0);
    send_request(OP_GET, 6'd0, 6'd63, 32'h0);
    send_request(OP_GET, 6'd0, 6'd1, 32'h0);
    send_request(OP_GET, 6'd63, 6'd0, 32'h1);
    send_request(OP_GET, 6'd21, 6'd42, 32'h0);
    send_request(OP_GET, 6'd42, 6'd21, 32'h0);
    send_request(OP_GET, 6'd0, 6'd21, 32'h0);

    mix = MIX_BALANCED;
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        case ($urandom_range(0, 3))
          0: mix = MIX_FILL;
          1: mix = MIX_DRAIN;
          default: mix = MIX_BALANCED;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (n == 1000) begin
        req_bus.valid <= 1'b0;
        do @(negedge clk); while (mailbox_pred.pending_count() != 0);
      end
      case (mix)
        MIX_FILL: add_pct = 90;
        MIX_DRAIN: add_pct = 15;
        default: add_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_GET;
      dst = pick_task_id();
      if (op == OP_GET && $urandom_range(0, 99) < 40) begin
        snd = NULL_ID;
      end else begin
        snd = pick_task_id();
      end
      send_request(op, snd, dst, $urandom);
      if (!no_gaps) begin
        idle_for(gap_length(1'b1));
      end
    end

    req_bus.valid <= 1'b0;
    while (mailbox_pred.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mailbox_pred.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
